[src/vertex_transform_light_setup_macros.svh]
// Assertion macros shared by the vertex transform and light setup design.
`ifndef VERTEX_TRANSFORM_LIGHT_SETUP_MACROS_SVH
`define VERTEX_TRANSFORM_LIGHT_SETUP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VTLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define VTLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/vtls_pkg.sv]
// Shared types, constants and helpers of the vertex transform and light setup.
`timescale 1ns / 1ps
package vtls_pkg;
  localparam int FRAC_BITS = 16;

  // Operation and configuration codes.
  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_VERTEX   = 1'b1;
  localparam logic CFG_LIGHT   = 1'b0;
  localparam logic CFG_NORMALS = 1'b1;
  localparam logic [1:0] LS_POINT = 2'd1;
  localparam logic [1:0] LS_DIR   = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_CLIP   = 3'd0;
  localparam logic [2:0] KIND_NORMAL = 3'd1;
  localparam logic [2:0] KIND_LIGHT  = 3'd2;
  localparam logic [2:0] KIND_VIEW   = 3'd3;
  localparam logic [2:0] KIND_HALF   = 3'd4;

  // Coefficient store layout.
  localparam logic [5:0] MV_BASE = 6'd0;
  localparam logic [5:0] PJ_BASE = 6'd16;
  localparam logic [5:0] LP_BASE = 6'd32;
  localparam logic [5:0] LD_BASE = 6'd35;

  typedef logic signed [31:0] word_t;
  typedef word_t [3:0] row_t;

  // Command word passed from the front to the back.
  typedef struct packed {
    logic          op;
    logic [5:0]    idx;
    word_t         value;
    word_t [3:0]   pos;
    word_t [2:0]   nrm;
    logic          lit;
    logic          dir;
  } cmd_t;

  // Result word.
  typedef struct packed {
    logic [2:0] kind;
    word_t      x;
    word_t      y;
    word_t      z;
    word_t      w;
    logic       mode;
    logic       last;
  } res_t;

  // Saturate a 33-bit signed value to 32 bits.
  function automatic word_t sat33(logic signed [32:0] v);
    word_t r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction
endpackage

[src/vertex_transform_light_setup.sv]
// Top level of the vertex transform and light setup block.
//
//   channel  | handshake          | word
//   ---------+--------------------+------------------------------------------
//   input    | push / full        | op, coef_index, coef_value, pos, normal
//   result   | pop / empty        | vector_kind, comp_x..w, mode, last flag
//   config   | cfg_valid/ready    | cfg_index, cfg_data
//
// A coefficient write is taken by the back while it is idle; a vertex then runs the
// transform (eleven dot products through one four-multiplier dot unit of two stages)
// and then hands over its results as one or five result words.
// The front takes a new word every cycle while its two-entry queue has room.
// Reset is synchronous; coefficient words hold no reset value until written.
// A stalled result side fills the four-entry result queue and then holds the back.
`timescale 1ns / 1ps
module vertex_transform_light_setup (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  logic            in_op,
  input  logic [5:0]      in_coef_index,
  input  vtls_pkg::word_t in_coef_value,
  input  vtls_pkg::word_t in_pos_x,
  input  vtls_pkg::word_t in_pos_y,
  input  vtls_pkg::word_t in_pos_z,
  input  vtls_pkg::word_t in_pos_w,
  input  vtls_pkg::word_t in_normal_x,
  input  vtls_pkg::word_t in_normal_y,
  input  vtls_pkg::word_t in_normal_z,
  output logic            empty,
  input  logic            pop,
  output logic [2:0]      out_vector_kind,
  output vtls_pkg::word_t out_comp_x,
  output vtls_pkg::word_t out_comp_y,
  output vtls_pkg::word_t out_comp_z,
  output vtls_pkg::word_t out_comp_w,
  output logic            out_shading_mode,
  output logic            out_last_of_vertex,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [1:0]      cfg_data
);
  import vtls_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;
  logic r_push;
  logic r_full;
  res_t r_word;
  res_t head;

  vtls_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_op         (in_op),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_pos_w      (in_pos_w),
    .in_normal_x   (in_normal_x),
    .in_normal_y   (in_normal_y),
    .in_normal_z   (in_normal_z),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  vtls_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .r_push  (r_push),
    .r_word  (r_word),
    .r_full  (r_full)
  );

  vtls_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .r_push (r_push),
    .r_word (r_word),
    .r_full (r_full),
    .pop    (pop),
    .empty  (empty),
    .head   (head)
  );

  assign out_vector_kind    = head.kind;
  assign out_comp_x         = head.x;
  assign out_comp_y         = head.y;
  assign out_comp_z         = head.z;
  assign out_comp_w         = head.w;
  assign out_shading_mode   = head.mode;
  assign out_last_of_vertex = head.last;
endmodule

[src/vtls_front.sv]
// Front part: configuration registers, item classification and command queue.
`timescale 1ns / 1ps
module vtls_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  logic           in_op,
  input  logic [5:0]     in_coef_index,
  input  vtls_pkg::word_t in_coef_value,
  input  vtls_pkg::word_t in_pos_x,
  input  vtls_pkg::word_t in_pos_y,
  input  vtls_pkg::word_t in_pos_z,
  input  vtls_pkg::word_t in_pos_w,
  input  vtls_pkg::word_t in_normal_x,
  input  vtls_pkg::word_t in_normal_y,
  input  vtls_pkg::word_t in_normal_z,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [1:0]     cfg_data,
  output logic           q_valid,
  output vtls_pkg::cmd_t q_cmd,
  input  logic           q_pop
);
  import vtls_pkg::*;

  logic [1:0] ls_r;
  logic       np_r;
  cmd_t       mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  cmd_t       cmd;
  logic       wr_en;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ls_r <= 2'd0;
      np_r <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_LIGHT) begin
        ls_r <= cfg_data;
      end else begin
        np_r <= cfg_data[0];
      end
    end
  end

  // Classify the incoming word: lighting mode and light type are fixed here.
  always_comb begin
    cmd.op    = in_op;
    cmd.idx   = in_coef_index;
    cmd.value = in_coef_value;
    cmd.pos   = {in_pos_w, in_pos_z, in_pos_y, in_pos_x};
    cmd.nrm   = {in_normal_z, in_normal_y, in_normal_x};
    cmd.lit   = np_r && (ls_r == LS_POINT || ls_r == LS_DIR);
    cmd.dir   = (ls_r == LS_DIR);
  end

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = mem_r[rp_r];
  assign wr_en   = push && !full;

  // Two-entry command queue.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= cmd;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, q_pop};
    end
  end
endmodule

[src/vtls_dot.sv]
// Two-stage four-term dot product unit with floor shift and saturation.
`timescale 1ns / 1ps
module vtls_dot (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  logic [3:0]     in_dest,
  input  vtls_pkg::row_t a,
  input  vtls_pkg::row_t b,
  output logic           out_vld,
  output logic [3:0]     out_dest,
  output vtls_pkg::word_t out_res
);
  import vtls_pkg::*;

  logic signed [63:0] prod_r [4];
  logic               v1_r;
  logic [3:0]         d1_r;
  logic signed [65:0] sum;
  logic signed [65:0] sh;
  word_t              res_r;
  logic               v2_r;
  logic [3:0]         d2_r;

  // Sum of exact products, arithmetic shift and saturation.
  always_comb begin
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      sum = sum + 66'(prod_r[i]);
    end
    sh = sum >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      prod_r[i] <= 64'($signed(a[i])) * 64'($signed(b[i]));
    end
    d1_r <= in_dest;
    d2_r <= d1_r;
    if (sh[65:31] == '0 || sh[65:31] == '1) begin
      res_r <= sh[31:0];
    end else begin
      res_r <= sh[65] ? 32'sh80000000 : 32'sh7fffffff;
    end
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  assign out_vld  = v2_r;
  assign out_dest = d2_r;
  assign out_res  = res_r;
endmodule

[src/vtls_back.sv]
// Back part: coefficient registers, transform sequencer and result assembly.
`timescale 1ns / 1ps
module vtls_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  vtls_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           r_push,
  output vtls_pkg::res_t r_word,
  input  logic           r_full
);
  import vtls_pkg::*;
  `include "vertex_transform_light_setup_macros.svh"

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_EMIT} state_t;

  localparam logic [3:0] STEP_NRM  = 4'd4;
  localparam logic [3:0] STEP_PJ   = 4'd7;
  localparam logic [3:0] STEP_LAST = 4'd10;
  localparam logic [3:0] STEP_DONE = 4'd12;

  state_t     state_r;
  logic [3:0] step_r;
  logic [2:0] kind_r;
  row_t       mv_r [4];
  row_t       pj_r [4];
  word_t      lp_r [3];
  word_t      ld_r [3];
  row_t       pos_r;
  word_t [2:0] nrm_r;
  row_t       p_r;
  row_t       c_r;
  word_t [2:0] n_r;
  logic       lit_r;
  logic       dir_r;

  logic       issue;
  row_t       a;
  row_t       b;
  logic [3:0] rel;
  logic       d_vld;
  logic [3:0] d_dest;
  word_t      d_res;
  logic [3:0] d_rel_n;
  logic [3:0] d_rel_p;
  logic [5:0] off_lp;
  logic [5:0] off_ld;
  word_t      lv [3];
  word_t      vv [3];
  word_t      hv [3];
  logic signed [32:0] hs [3];

  assign q_pop  = q_valid && (state_r == S_IDLE);
  assign issue  = (state_r == S_CALC) && (step_r <= STEP_LAST);
  assign off_lp = q_cmd.idx - LP_BASE;
  assign off_ld = q_cmd.idx - LD_BASE;

  // Operand selection: model-view rows on position, then on normal, then projection.
  always_comb begin
    rel = 4'd0;
    a   = mv_r[step_r[1:0]];
    b   = pos_r;
    if (step_r >= STEP_PJ) begin
      rel = step_r - STEP_PJ;
      a   = pj_r[rel[1:0]];
      b   = p_r;
    end else if (step_r >= STEP_NRM) begin
      rel = step_r - STEP_NRM;
      a   = mv_r[rel[1:0]];
      b   = {32'sd0, nrm_r[2], nrm_r[1], nrm_r[0]};
    end
  end

  vtls_dot u_dot (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (issue),
    .in_dest  (step_r),
    .a        (a),
    .b        (b),
    .out_vld  (d_vld),
    .out_dest (d_dest),
    .out_res  (d_res)
  );

  assign d_rel_n = d_dest - STEP_NRM;
  assign d_rel_p = d_dest - STEP_PJ;

  // Light, view and half vectors from the saturated eye position.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vv[i] = sat33(-33'(p_r[i]));
      if (dir_r) begin
        lv[i] = sat33(-33'(ld_r[i]));
      end else begin
        lv[i] = sat33(33'(lp_r[i]) - 33'(p_r[i]));
      end
      hs[i] = 33'(vv[i]) + 33'(lv[i]);
      hv[i] = hs[i][32:1];
    end
  end

  // Result word for the current kind.
  always_comb begin
    r_word.kind = kind_r;
    r_word.mode = lit_r;
    r_word.w    = 32'sd0;
    r_word.last = 1'b0;
    r_word.x    = c_r[0];
    r_word.y    = c_r[1];
    r_word.z    = c_r[2];
    case (kind_r)
      KIND_CLIP: begin
        r_word.w    = c_r[3];
        r_word.last = !lit_r;
      end
      KIND_NORMAL: begin
        r_word.x = n_r[0];
        r_word.y = n_r[1];
        r_word.z = n_r[2];
      end
      KIND_LIGHT: begin
        r_word.x = lv[0];
        r_word.y = lv[1];
        r_word.z = lv[2];
      end
      KIND_VIEW: begin
        r_word.x = vv[0];
        r_word.y = vv[1];
        r_word.z = vv[2];
      end
      default: begin
        r_word.x    = hv[0];
        r_word.y    = hv[1];
        r_word.z    = hv[2];
        r_word.last = 1'b1;
      end
    endcase
  end

  assign r_push = (state_r == S_EMIT) && !r_full;

  // Sequencer state and data registers.
  always_ff @(posedge clk) begin
    if (d_vld) begin
      if (d_dest >= STEP_PJ) begin
        c_r[d_rel_p[1:0]] <= d_res;
      end else if (d_dest >= STEP_NRM) begin
        n_r[d_rel_n[1:0]] <= d_res;
      end else begin
        p_r[d_dest[1:0]] <= d_res;
      end
    end
    if (q_pop) begin
      pos_r <= q_cmd.pos;
      nrm_r <= q_cmd.nrm;
      lit_r <= q_cmd.lit;
      dir_r <= q_cmd.dir;
      if (q_cmd.op == OP_WRITE) begin
        if (q_cmd.idx inside {[MV_BASE:PJ_BASE - 6'd1]}) begin
          mv_r[q_cmd.idx[3:2]][q_cmd.idx[1:0]] <= q_cmd.value;
        end else if (q_cmd.idx inside {[PJ_BASE:LP_BASE - 6'd1]}) begin
          pj_r[q_cmd.idx[3:2]][q_cmd.idx[1:0]] <= q_cmd.value;
        end else if (q_cmd.idx inside {[LP_BASE:LD_BASE - 6'd1]}) begin
          lp_r[off_lp[1:0]] <= q_cmd.value;
        end else if (q_cmd.idx inside {[LD_BASE:LD_BASE + 6'd2]}) begin
          ld_r[off_ld[1:0]] <= q_cmd.value;
        end
      end
    end
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= 4'd0;
      kind_r  <= KIND_CLIP;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_pop && q_cmd.op == OP_VERTEX) begin
            state_r <= S_CALC;
            step_r  <= 4'd0;
          end
        end
        S_CALC: begin
          step_r <= step_r + 4'd1;
          if (step_r == STEP_DONE) begin
            state_r <= S_EMIT;
            kind_r  <= KIND_CLIP;
          end
        end
        S_EMIT: begin
          if (r_push) begin
            if (r_word.last) begin
              state_r <= S_IDLE;
            end else begin
              kind_r <= kind_r + 3'd1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `VTLS_ASSERT_NOW(a_dot_in_calc, d_vld, state_r == S_CALC, "dot result outside calculation")
  `VTLS_ASSERT_NOW(a_pop_idle, q_pop, $past(state_r) != S_EMIT || state_r == S_IDLE, "pop while busy")
  `VTLS_ASSERT_NEXT(a_last_idle, r_push && r_word.last, state_r == S_IDLE, "no return to idle")
  `VTLS_ASSERT_NOW(a_kind_range, state_r == S_EMIT, kind_r <= KIND_HALF, "kind out of range")
endmodule

[src/vtls_outq.sv]
// Four-entry result queue.
`timescale 1ns / 1ps
module vtls_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           r_push,
  input  vtls_pkg::res_t r_word,
  output logic           r_full,
  input  logic           pop,
  output logic           empty,
  output vtls_pkg::res_t head
);
  import vtls_pkg::*;

  res_t       mem_r [4];
  logic [1:0] wp_r;
  logic [1:0] rp_r;
  logic [2:0] cnt_r;
  logic       rd_en;

  assign r_full = (cnt_r == 3'd4);
  assign empty  = (cnt_r == 3'd0);
  assign head   = mem_r[rp_r];
  assign rd_en  = pop && !empty;

  // Storage and pointers.
  always_ff @(posedge clk) begin
    if (r_push) begin
      mem_r[wp_r] <= r_word;
    end
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (r_push) begin
        wp_r <= wp_r + 2'd1;
      end
      if (rd_en) begin
        rp_r <= rp_r + 2'd1;
      end
      cnt_r <= cnt_r + {2'b0, r_push} - {2'b0, rd_en};
    end
  end
endmodule

[dv/vtls_checker.sv]
// Checker for the vertex transform and light setup block: it predicts results and compares them.
`timescale 1ns / 1ps
module vtls_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic            full,
  input  logic            in_op,
  input  logic [5:0]      in_coef_index,
  input  vtls_pkg::word_t in_coef_value,
  input  vtls_pkg::word_t in_pos_x,
  input  vtls_pkg::word_t in_pos_y,
  input  vtls_pkg::word_t in_pos_z,
  input  vtls_pkg::word_t in_pos_w,
  input  vtls_pkg::word_t in_normal_x,
  input  vtls_pkg::word_t in_normal_y,
  input  vtls_pkg::word_t in_normal_z,
  input  logic            empty,
  input  logic            pop,
  input  logic [2:0]      out_vector_kind,
  input  vtls_pkg::word_t out_comp_x,
  input  vtls_pkg::word_t out_comp_y,
  input  vtls_pkg::word_t out_comp_z,
  input  vtls_pkg::word_t out_comp_w,
  input  logic            out_shading_mode,
  input  logic            out_last_of_vertex,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [1:0]      cfg_data,
  output int              fail_count,
  output int              pending_count,
  output int              checked_count
);
  import vtls_pkg::*;

  word_t       coef_mem [64];
  logic [1:0]  light_sel;
  logic        has_normals;
  res_t        pending_results [$];

  // Clamps a wide signed value to the 32-bit range.
  function automatic word_t clamp32(logic signed [66:0] v);
    if (v > 67'sd2147483647) return 32'sh7fffffff;
    if (v < -67'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Dot product of a store row with the first n entries of a vector, floored.
  function automatic word_t row_dot(int base, row_t vec, int n);
    logic signed [66:0] acc;
    longint             prod;
    acc = '0;
    for (int i = 0; i < n; i++) begin
      prod = longint'(coef_mem[base + i]) * longint'(vec[i]);
      acc = acc + prod;
    end
    return clamp32(acc >>> FRAC_BITS);
  endfunction

  // Computes every result word that one vertex produces.
  task automatic transform_vertex(row_t pos, row_t nrm);
    row_t               eye, clip, nv, lv, vv, hv;
    logic               lit;
    logic signed [66:0] t;
    res_t               r;
    for (int i = 0; i < 4; i++) eye[i] = row_dot(4 * i, pos, 4);
    for (int i = 0; i < 4; i++) clip[i] = row_dot(16 + 4 * i, eye, 4);
    lit = has_normals && (light_sel == LS_POINT || light_sel == LS_DIR);
    r = '{kind: KIND_CLIP, x: clip[0], y: clip[1], z: clip[2], w: clip[3],
          mode: lit, last: !lit};
    pending_results.push_back(r);
    if (!lit) return;
    for (int i = 0; i < 3; i++) begin
      nv[i] = row_dot(4 * i, nrm, 3);
      if (light_sel == LS_DIR) lv[i] = clamp32(-67'(coef_mem[35 + i]));
      else lv[i] = clamp32(67'(coef_mem[32 + i]) - 67'(eye[i]));
      vv[i] = clamp32(-67'(eye[i]));
      t = 67'(vv[i]) + 67'(lv[i]);
      hv[i] = clamp32(t >>> 1);
    end
    pending_results.push_back('{KIND_NORMAL, nv[0], nv[1], nv[2], 32'sd0, 1'b1, 1'b0});
    pending_results.push_back('{KIND_LIGHT, lv[0], lv[1], lv[2], 32'sd0, 1'b1, 1'b0});
    pending_results.push_back('{KIND_VIEW, vv[0], vv[1], vv[2], 32'sd0, 1'b1, 1'b0});
    pending_results.push_back('{KIND_HALF, hv[0], hv[1], hv[2], 32'sd0, 1'b1, 1'b1});
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  assign pending_count = pending_results.size();

  // Watch the three channels on every rising edge.
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      light_sel = 2'd0;
      has_normals = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_LIGHT) light_sel = cfg_data;
        else has_normals = cfg_data[0];
      end
      if (pop && !empty) begin
        checked_count++;
        if (pending_results.size() == 0) begin
          $error("result word arrived with nothing expected");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("vector_kind", want.kind, out_vector_kind);
          check_field("comp_x", want.x, out_comp_x);
          check_field("comp_y", want.y, out_comp_y);
          check_field("comp_z", want.z, out_comp_z);
          check_field("comp_w", want.w, out_comp_w);
          check_field("shading_mode", want.mode, out_shading_mode);
          check_field("last_of_vertex", want.last, out_last_of_vertex);
        end
      end
      if (push && !full) begin
        if (in_op == OP_WRITE) coef_mem[in_coef_index] = in_coef_value;
        else transform_vertex({in_pos_w, in_pos_z, in_pos_y, in_pos_x},
                              {32'sd0, in_normal_z, in_normal_y, in_normal_x});
      end
    end
  end

  initial begin
    fail_count = 0;
    checked_count = 0;
  end
endmodule

[dv/tb.sv]
// Testbench top for the vertex transform and light setup block: stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import vtls_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       push, full, in_op, empty, pop;
  logic [5:0] in_coef_index;
  word_t      in_coef_value, in_pos_x, in_pos_y, in_pos_z, in_pos_w;
  word_t      in_normal_x, in_normal_y, in_normal_z;
  logic [2:0] out_vector_kind;
  word_t      out_comp_x, out_comp_y, out_comp_z, out_comp_w;
  logic       out_shading_mode, out_last_of_vertex;
  logic       cfg_valid, cfg_ready, cfg_index;
  logic [1:0] cfg_data;
  int         fail_count, pending_count, checked_count;
  int         words_sent;
  logic       calm;

  always #10 clk = ~clk;

  vertex_transform_light_setup u_dut (.*);
  vtls_checker u_checker (.*);

  // Mix of coefficient and coordinate values: random, near one, small and extreme.
  function automatic word_t pick_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'sh00010000 + $signed($urandom_range(0, 8191)) - 32'sd4096;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      3: return -32'sh00010000;
      default: return $signed($urandom_range(0, 32'h00080000)) - 32'sh00040000;
    endcase
  endfunction

  // Drives one input word and holds it until the block takes it.
  task automatic send_word(logic op, logic [5:0] idx, word_t val, row_t pos, row_t nrm);
    push <= 1'b1;
    in_op <= op;
    in_coef_index <= idx;
    in_coef_value <= val;
    {in_pos_w, in_pos_z, in_pos_y, in_pos_x} <= pos;
    {in_normal_z, in_normal_y, in_normal_x} <= nrm[2:0];
    do @(posedge clk); while (full);
    words_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_vertex(row_t pos, row_t nrm);
    send_word(OP_VERTEX, 6'($urandom), $urandom, pos, nrm);
  endtask

  task automatic send_coef(logic [5:0] idx, word_t val);
    send_word(OP_WRITE, idx, val, {4{word_t'($urandom)}}, {4{word_t'($urandom)}});
  endtask

  // Waits for the block to drain, then writes one register.
  task automatic write_reg(logic idx, logic [1:0] data);
    push <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n);
    row_t pos, nrm;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 4; k++) begin
        pos[k] = pick_word();
        nrm[k] = pick_word();
      end
      if ($urandom_range(0, 9) < 3) send_coef(6'($urandom), pick_word());
      else send_vertex(pos, nrm);
    end
  endtask

  // Result side: random stall bursts, none in the calm part.
  initial begin
    int stall;
    pop = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (calm) begin
        pop <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 12) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    #8ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence.
  initial begin
    int cnt;
    push = 1'b0;
    in_op = OP_WRITE;
    in_coef_index = '0;
    in_coef_value = '0;
    {in_pos_x, in_pos_y, in_pos_z, in_pos_w} = '0;
    {in_normal_x, in_normal_y, in_normal_z} = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LIGHT;
    cfg_data = '0;
    calm = 1'b0;
    words_sent = 0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity matrices and a light, so every later vertex reads written words.
    for (int i = 0; i < 32; i++)
      send_coef(6'(i), (i % 16) % 5 == 0 ? 32'sh00010000 : 32'sd0);
    for (int i = 32; i < 38; i++) send_coef(6'(i), 32'sh00020000);
    send_coef(6'd63, 32'sh7fffffff);
    send_vertex({32'sh00010000, 32'sh7fffffff, 32'sh80000000, 32'sd0},
                {32'sd0, 32'sh80000000, 32'sh7fffffff, 32'sh00010000});
    write_reg(CFG_NORMALS, 2'd3);
    write_reg(CFG_LIGHT, LS_POINT);
    send_vertex({32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000},
                {32'sd0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff});
    send_coef(6'd32, 32'sh80000000);
    send_coef(6'd0, 32'sh7fffffff);
    send_vertex({32'sh00010000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff},
                {32'sd0, 32'sh00010000, 32'sh00010000, 32'sh80000000});
    write_reg(CFG_LIGHT, LS_DIR);
    send_coef(6'd35, 32'sh80000000);
    send_vertex({32'sh00010000, 32'sh00020000, 32'sh80000000, 32'sh00010000},
                {32'sd0, 32'sh00010000, 32'sh00010000, 32'sh00010000});

    // Random phases under a spread of register settings; the last one runs calm.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin write_reg(CFG_LIGHT, 2'd0); write_reg(CFG_NORMALS, 2'd2); end
        1: begin write_reg(CFG_LIGHT, LS_POINT); write_reg(CFG_NORMALS, 2'd1); end
        2: write_reg(CFG_LIGHT, 2'd3);
        3: write_reg(CFG_LIGHT, LS_DIR);
        4: write_reg(CFG_NORMALS, 2'd0);
        5: begin write_reg(CFG_LIGHT, LS_POINT); write_reg(CFG_NORMALS, 2'd1); end
        default: begin write_reg(CFG_LIGHT, LS_DIR); calm = 1'b1; end
      endcase
      random_phase(ph == 6 ? 30 : 50);
    end
    push <= 1'b0;

    cnt = 0;
    while (pending_count != 0 && cnt < 20000) begin
      @(posedge clk);
      cnt++;
    end
    repeat (40) @(posedge clk);
    $display("Sent %0d input words across seven register settings; checked %0d result words.",
             words_sent, checked_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (pending_count != 0) $error("%0d expected result words never arrived", pending_count);
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
